// File: design/assert_macros.svh
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define SQW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define SQW_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: design/sqw_pkg.sv
// Types, codes, constants and helper functions of the square wave sound channel.
package sqw_pkg;

  typedef enum logic [2:0] {
    KIND_WRITE    = 3'd0,
    KIND_READ     = 3'd1,
    KIND_ADVANCE  = 3'd2,
    KIND_LENGTH   = 3'd3,
    KIND_ENVELOPE = 3'd4,
    KIND_SWEEP    = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    REG_SWEEP    = 3'd0,
    REG_LEN_DUTY = 3'd1,
    REG_VOL_ENV  = 3'd2,
    REG_PER_LO   = 3'd3,
    REG_PER_HI   = 3'd4
  } reg_e;

  typedef enum logic [2:0] {
    CFG_HAS_SWEEP = 3'd0,
    CFG_DUTY_0    = 3'd1,
    CFG_DUTY_1    = 3'd2,
    CFG_DUTY_2    = 3'd3,
    CFG_DUTY_3    = 3'd4
  } cfg_idx_e;

  localparam logic       HAS_SWEEP_RST = 1'b1;
  localparam logic [7:0] DUTY_0_RST    = 8'd1;
  localparam logic [7:0] DUTY_1_RST    = 8'd129;
  localparam logic [7:0] DUTY_2_RST    = 8'd135;
  localparam logic [7:0] DUTY_3_RST    = 8'd126;

  localparam logic [7:0]  DAC_MASK     = 8'b1111_1000;
  localparam logic [11:0] PERIOD_MAX   = 12'h7FF;
  localparam logic [11:0] RELOAD_BASE  = 12'd2048;
  localparam logic [7:0]  LENGTH_LIMIT = 8'd64;
  localparam logic [7:0]  DUTY_RD_MASK = 8'b1100_0000;
  localparam logic [7:0]  LEN_EN_MASK  = 8'b0100_0000;

  typedef struct packed {
    logic [2:0] kind;
    logic [2:0] reg_index;
    logic [7:0] write_data;
    logic [7:0] cycles;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       read_valid;
    logic [3:0] sample_level;
    logic       channel_on;
  } result_t;

  typedef struct packed {
    logic            has_sweep;
    logic [3:0][7:0] duty;
  } cfg_t;

  typedef struct packed {
    logic        enabled;
    logic [2:0]  duty_pos;
    logic [15:0] countdown;
    logic [7:0]  sweep_reg;
    logic [7:0]  len_duty;
    logic [7:0]  vol_env;
    logic [7:0]  per_lo;
    logic [7:0]  per_hi;
    logic [6:0]  len_cnt;
    logic [3:0]  env_cnt;
    logic [3:0]  vol;
    logic        env_act;
    logic [2:0]  sweep_cnt;
    logic [2:0]  sweep_pace;
  } state_t;

  // Next period of the sweep unit; bit 11 set means overflow.
  function automatic logic [11:0] sweep_target(input logic [10:0] p, input logic [7:0] sw);
    logic [11:0] base;
    logic [11:0] delta;
    base  = {1'b0, p};
    delta = base >> sw[2:0];
    return sw[3] ? base - delta : base + delta;
  endfunction

endpackage

// File: design/sqw_intf.sv
// Handshake interfaces for the item, result and configuration channels.
interface sqw_item_if import sqw_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [2:0] reg_index;
  logic [7:0] write_data;
  logic [7:0] cycles;

  modport source (output valid, kind, reg_index, write_data, cycles, input ready);
  modport sink   (input valid, kind, reg_index, write_data, cycles, output ready);
endinterface

interface sqw_result_if import sqw_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       read_valid;
  logic [3:0] sample_level;
  logic       channel_on;

  modport source (output valid, read_data, read_valid, sample_level, channel_on, input ready);
  modport sink   (input valid, read_data, read_valid, sample_level, channel_on, output ready);
endinterface

interface sqw_cfg_if import sqw_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [2:0] addr;
  logic [7:0] wdata;

  modport source (output valid, addr, wdata, input ready);
  modport sink   (input valid, addr, wdata, output ready);
endinterface

// File: design/sqw_cfg.sv
// Configuration register file: sweep enable and the four duty waveforms.
module sqw_cfg import sqw_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  sqw_cfg_if.sink   cfg_i,
  output cfg_t      cfg_o
);

  cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.has_sweep <= HAS_SWEEP_RST;
      cfg_q.duty[0]   <= DUTY_0_RST;
      cfg_q.duty[1]   <= DUTY_1_RST;
      cfg_q.duty[2]   <= DUTY_2_RST;
      cfg_q.duty[3]   <= DUTY_3_RST;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.addr)
        CFG_HAS_SWEEP: cfg_q.has_sweep <= cfg_i.wdata[0];
        CFG_DUTY_0:    cfg_q.duty[0]   <= cfg_i.wdata;
        CFG_DUTY_1:    cfg_q.duty[1]   <= cfg_i.wdata;
        CFG_DUTY_2:    cfg_q.duty[2]   <= cfg_i.wdata;
        CFG_DUTY_3:    cfg_q.duty[3]   <= cfg_i.wdata;
        default: ;
      endcase
    end
  end

endmodule

// File: design/sqw_step.sv
// Next-state and result logic for one item applied to the channel state.
module sqw_step import sqw_pkg::*; (
  input  cfg_t    cfg_i,
  input  state_t  st_i,
  input  item_t   item_i,
  output state_t  st_o,
  output result_t res_o
);

  logic [10:0] period;
  logic [17:0] cd_sub;
  logic [17:0] reload;
  logic [17:0] cd_new;
  logic [11:0] np1;
  logic [11:0] np2;
  logic [7:0]  len_nx;
  logic [4:0]  env_nx;
  logic [4:0]  env_pace;
  logic [2:0]  sc;
  logic [7:0]  pat;
  state_t      nx;
  result_t     res;

  always_comb begin
    nx  = st_i;
    res = '0;

    period   = {st_i.per_hi[2:0], st_i.per_lo};
    // countdown is two's complement; work in 18 bits so the borrow is visible
    cd_sub   = {{2{st_i.countdown[15]}}, st_i.countdown} - {10'd0, item_i.cycles};
    reload   = {4'd0, RELOAD_BASE - {1'b0, period}, 2'b00};
    cd_new   = cd_sub + reload;
    np1      = sweep_target(period, st_i.sweep_reg);
    np2      = sweep_target(np1[10:0], st_i.sweep_reg);
    len_nx   = {1'b0, st_i.len_cnt} + 8'd1;
    env_pace = {2'b00, st_i.vol_env[2:0]};
    env_nx   = {1'b0, st_i.env_cnt} + 5'd1;
    sc       = st_i.sweep_cnt + 3'd1;

    unique case (item_i.kind)
      KIND_WRITE: begin
        unique case (item_i.reg_index)
          REG_SWEEP: begin
            if (cfg_i.has_sweep) begin
              nx.sweep_reg = item_i.write_data;
              if (item_i.write_data[6:4] == 3'd0 || st_i.sweep_pace == 3'd0) begin
                nx.sweep_pace = item_i.write_data[6:4];
              end
            end
          end
          REG_LEN_DUTY: begin
            nx.len_duty = item_i.write_data;
            nx.len_cnt  = {1'b0, item_i.write_data[5:0]};
          end
          REG_VOL_ENV: begin
            nx.vol_env = item_i.write_data;
            if ((item_i.write_data & DAC_MASK) == 8'd0) begin
              nx.enabled = 1'b0;
            end
          end
          REG_PER_LO: nx.per_lo = item_i.write_data;
          REG_PER_HI: begin
            nx.per_hi = item_i.write_data;
            if (item_i.write_data[7]) begin
              // trigger loads the raw period, not the reload value
              nx.enabled   = 1'b1;
              nx.duty_pos  = 3'd0;
              nx.countdown = {5'd0, item_i.write_data[2:0], st_i.per_lo};
              nx.vol       = st_i.vol_env[7:4];
              nx.env_act   = 1'b1;
              nx.len_cnt   = {1'b0, st_i.len_duty[5:0]};
              if (cfg_i.has_sweep) begin
                nx.sweep_pace = st_i.sweep_reg[6:4];
              end
            end
          end
          default: ;
        endcase
      end
      KIND_READ: begin
        if (item_i.reg_index == REG_LEN_DUTY) begin
          res.read_data  = st_i.len_duty & DUTY_RD_MASK;
          res.read_valid = 1'b1;
        end else if (item_i.reg_index == REG_PER_HI) begin
          res.read_data  = st_i.per_hi & LEN_EN_MASK;
          res.read_valid = 1'b1;
        end
      end
      KIND_ADVANCE: begin
        if (st_i.enabled) begin
          if (cd_sub[17] || cd_sub == 18'd0) begin
            nx.countdown = cd_new[15:0];
            nx.duty_pos  = st_i.duty_pos + 3'd1;
          end else begin
            nx.countdown = cd_sub[15:0];
          end
        end
      end
      KIND_LENGTH: begin
        if ((st_i.per_hi & LEN_EN_MASK) != 8'd0) begin
          if (len_nx >= LENGTH_LIMIT) begin
            nx.len_cnt = 7'd0;
            nx.enabled = 1'b0;
          end else begin
            nx.len_cnt = len_nx[6:0];
          end
        end
      end
      KIND_ENVELOPE: begin
        if (env_nx < env_pace) begin
          nx.env_cnt = env_nx[3:0];
        end else if (env_pace == 5'd0 || !st_i.env_act) begin
          nx.env_cnt = 4'd0;
        end else begin
          nx.env_cnt = 4'(env_nx - env_pace);
          // volume clamps at either end and the envelope stops
          if (st_i.vol_env[3]) begin
            if (st_i.vol == 4'd15) nx.env_act = 1'b0;
            else                   nx.vol     = st_i.vol + 4'd1;
          end else begin
            if (st_i.vol == 4'd0)  nx.env_act = 1'b0;
            else                   nx.vol     = st_i.vol - 4'd1;
          end
        end
      end
      KIND_SWEEP: begin
        if (cfg_i.has_sweep && st_i.enabled) begin
          if (st_i.sweep_reg[2:0] == 3'd0 && st_i.sweep_pace == 3'd0) begin
            nx.sweep_cnt = 3'd0;
          end else if (sc < st_i.sweep_pace) begin
            nx.sweep_cnt = sc;
          end else begin
            nx.sweep_cnt  = 3'd0;
            nx.sweep_pace = st_i.sweep_reg[6:4];
            if (np1 > PERIOD_MAX) begin
              nx.enabled = 1'b0;
            end else begin
              nx.per_hi = {st_i.per_hi[7:3], np1[10:8]};
              nx.per_lo = np1[7:0];
              // overflow check repeated on the freshly stored period
              if (np2 > PERIOD_MAX) nx.enabled = 1'b0;
            end
          end
        end
      end
      default: ;
    endcase

    pat = cfg_i.duty[nx.len_duty[7:6]];
    if (nx.enabled && pat[~nx.duty_pos]) begin
      res.sample_level = nx.vol;
    end
    res.channel_on = nx.enabled;

    st_o  = nx;
    res_o = res;
  end

endmodule

// File: design/square_wave_sound_channel.sv
// Top level of the square wave sound channel: item, state and result registers.
//
// Usage:
// - cfg_i writes the sweep enable (index 0) and the four duty waveforms
//   (index 1..4); it is always ready. Write it only while the channel is idle.
// - item_i carries register writes and reads, cycle advances and length,
//   envelope and sweep ticks. Each transaction yields exactly one result on
//   result_o: read data for reads, and the sample level and on flag after
//   the item has been applied.
// - An accepted item is held in the item register; the result register loads
//   from it when result_o is empty or being taken. Throughput is one item
//   per cycle while result_o does not stall, set by the single
//   state-update pass between the item and result registers.
// - When result_o stalls, the result register holds and one more item waits
//   in the item register; item_i.ready drops only when both are full.
// - Reset clears the channel state to off with all registers zero, empties
//   both stages, and loads the default sweep enable and duty waveforms.
`include "assert_macros.svh"

module square_wave_sound_channel import sqw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  sqw_item_if.sink    item_i,
  sqw_result_if.source result_o,
  sqw_cfg_if.sink     cfg_i
);

  cfg_t    cfg;
  item_t   item_q;
  logic    in_vld_q;
  state_t  st_q;
  state_t  st_d;
  result_t res_q;
  result_t res_d;
  logic    out_vld_q;
  logic    adv;

  sqw_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  sqw_step u_step (
    .cfg_i  (cfg),
    .st_i   (st_q),
    .item_i (item_q),
    .st_o   (st_d),
    .res_o  (res_d)
  );

  assign adv          = in_vld_q && (!out_vld_q || result_o.ready);
  assign item_i.ready = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (item_i.valid && item_i.ready) begin
      in_vld_q <= 1'b1;
    end else if (adv) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_i.valid && item_i.ready) begin
      item_q.kind       <= item_i.kind;
      item_q.reg_index  <= item_i.reg_index;
      item_q.write_data <= item_i.write_data;
      item_q.cycles     <= item_i.cycles;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (adv) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (result_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign result_o.valid        = out_vld_q;
  assign result_o.read_data    = res_q.read_data;
  assign result_o.read_valid   = res_q.read_valid;
  assign result_o.sample_level = res_q.sample_level;
  assign result_o.channel_on   = res_q.channel_on;

  `SQW_ASSERT_ALWAYS(a_rst_empty, !rst_ni |-> (!in_vld_q && !out_vld_q), "stage valid during reset")
  `SQW_ASSERT(a_stall_holds_item, in_vld_q && out_vld_q && !result_o.ready |=> in_vld_q && $stable(item_q), "pending item lost while result stalled")
  `SQW_ASSERT(a_on_matches_state, adv |=> (res_q.channel_on == st_q.enabled), "result on flag differs from channel state")

endmodule

// File: verif/sqw_channel_checker.sv
// Checker for the pulse channel: mirrors the channel state and compares every result.
`timescale 1ns / 100ps

module sqw_channel_checker import sqw_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  sqw_item_if   item_i,
  sqw_result_if result_i,
  sqw_cfg_if    cfg_i,
  output int    fail_count_o,
  output int    outstanding_o
);

  // Configuration copy
  logic       sweep_fitted;
  logic [7:0] wave [4];

  // Channel state copy
  logic        on;
  logic [2:0]  step_pos;
  logic [15:0] countdown;
  logic [7:0]  sweep_r;
  logic [7:0]  len_duty_r;
  logic [7:0]  vol_env_r;
  logic [7:0]  per_lo_r;
  logic [7:0]  per_hi_r;
  logic [6:0]  len_cnt;
  logic [3:0]  env_cnt;
  logic [3:0]  vol;
  logic        env_run;
  logic [2:0]  sweep_cnt;
  logic [2:0]  sweep_pace;

  result_t pending_results [$];

  function automatic void reset_channel();
    sweep_fitted = HAS_SWEEP_RST;
    wave[0]      = DUTY_0_RST;
    wave[1]      = DUTY_1_RST;
    wave[2]      = DUTY_2_RST;
    wave[3]      = DUTY_3_RST;
    on           = 1'b0;
    step_pos     = '0;
    countdown    = '0;
    sweep_r      = '0;
    len_duty_r   = '0;
    vol_env_r    = '0;
    per_lo_r     = '0;
    per_hi_r     = '0;
    len_cnt      = '0;
    env_cnt      = '0;
    vol          = '0;
    env_run      = 1'b0;
    sweep_cnt    = '0;
    sweep_pace   = '0;
  endfunction

  function automatic logic [10:0] period_now();
    return {per_hi_r[2:0], per_lo_r};
  endfunction

  function automatic int sweep_next();
    int p;
    int d;
    p = int'(period_now());
    d = p >> sweep_r[2:0];
    return sweep_r[3] ? p - d : p + d;
  endfunction

  function automatic void retrigger();
    on        = 1'b1;
    step_pos  = '0;
    // trigger loads the raw period, not the reload value
    countdown = {5'd0, period_now()};
    vol       = vol_env_r[7:4];
    env_run   = 1'b1;
    len_cnt   = {1'b0, len_duty_r[5:0]};
    if (sweep_fitted) sweep_pace = sweep_r[6:4];
  endfunction

  function automatic void write_reg(logic [2:0] idx, logic [7:0] d);
    case (idx)
      REG_SWEEP: begin
        if (sweep_fitted) begin
          sweep_r = d;
          if (sweep_r[6:4] == 3'd0 || sweep_pace == 3'd0) sweep_pace = sweep_r[6:4];
        end
      end
      REG_LEN_DUTY: begin
        len_duty_r = d;
        len_cnt    = {1'b0, d[5:0]};
      end
      REG_VOL_ENV: begin
        vol_env_r = d;
        if ((d & DAC_MASK) == 8'd0) on = 1'b0;
      end
      REG_PER_LO: per_lo_r = d;
      REG_PER_HI: begin
        per_hi_r = d;
        if (d[7]) retrigger();
      end
      default: ;
    endcase
  endfunction

  function automatic void advance(logic [7:0] n);
    int c;
    if (!on) return;
    c = int'($signed(countdown)) - int'(n);
    if (c <= 0) begin
      c        = c + (int'(RELOAD_BASE) - int'(period_now())) * 4;
      step_pos = step_pos + 3'd1;
    end
    countdown = c[15:0];
  endfunction

  function automatic void length_tick();
    if ((per_hi_r & LEN_EN_MASK) == 8'd0) return;
    len_cnt = len_cnt + 7'd1;
    if (len_cnt >= LENGTH_LIMIT) begin
      len_cnt = '0;
      on      = 1'b0;
    end
  endfunction

  function automatic void envelope_tick();
    int pace;
    int cnt;
    pace = int'(vol_env_r[2:0]);
    cnt  = int'(env_cnt) + 1;
    if (cnt < pace) begin
      env_cnt = cnt[3:0];
    end else if (pace == 0 || !env_run) begin
      env_cnt = '0;
    end else begin
      env_cnt = 4'(cnt - pace);
      // clamp at either end stops the envelope until the next trigger
      if (vol_env_r[3]) begin
        if (vol == 4'd15) env_run = 1'b0;
        else vol = vol + 4'd1;
      end else begin
        if (vol == 4'd0) env_run = 1'b0;
        else vol = vol - 4'd1;
      end
    end
  endfunction

  function automatic void sweep_tick();
    int np;
    if (!sweep_fitted || !on) return;
    if (sweep_r[2:0] == 3'd0 && sweep_pace == 3'd0) begin
      sweep_cnt = '0;
      return;
    end
    sweep_cnt = sweep_cnt + 3'd1;
    if (sweep_cnt < sweep_pace) return;
    sweep_cnt  = '0;
    sweep_pace = sweep_r[6:4];
    np         = sweep_next();
    if (np > int'(PERIOD_MAX)) begin
      on = 1'b0;
      return;
    end
    per_hi_r = {per_hi_r[7:3], np[10:8]};
    per_lo_r = np[7:0];
    // second overflow check against the updated period
    if (sweep_next() > int'(PERIOD_MAX)) on = 1'b0;
  endfunction

  function automatic result_t channel_step(item_t it);
    result_t    res;
    logic [7:0] pat;
    res = '0;
    case (it.kind)
      KIND_WRITE: write_reg(it.reg_index, it.write_data);
      KIND_READ: begin
        if (it.reg_index == REG_LEN_DUTY) begin
          res.read_data  = len_duty_r & DUTY_RD_MASK;
          res.read_valid = 1'b1;
        end else if (it.reg_index == REG_PER_HI) begin
          res.read_data  = per_hi_r & LEN_EN_MASK;
          res.read_valid = 1'b1;
        end
      end
      KIND_ADVANCE:  advance(it.cycles);
      KIND_LENGTH:   length_tick();
      KIND_ENVELOPE: envelope_tick();
      KIND_SWEEP:    sweep_tick();
      default: ;
    endcase
    if (on) begin
      pat = wave[len_duty_r[7:6]];
      if (pat[3'd7 - step_pos]) res.sample_level = vol;
    end
    res.channel_on = on;
    return res;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    item_t   it;
    if (!rst_ni) begin
      reset_channel();
      pending_results.delete();
      outstanding_o = 0;
      fail_count_o  = 0;
    end else begin
      if (result_i.valid && result_i.ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result with nothing pending, expected none actual %0h/%0h/%0h/%0h",
                   $time, result_i.read_data, result_i.read_valid,
                   result_i.sample_level, result_i.channel_on);
          fail_count_o++;
        end else begin
          want = pending_results.pop_front();
          outstanding_o--;
          check_field("read_data", want.read_data, result_i.read_data);
          check_field("read_valid", want.read_valid, result_i.read_valid);
          check_field("sample_level", want.sample_level, result_i.sample_level);
          check_field("channel_on", want.channel_on, result_i.channel_on);
        end
      end
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.addr)
          CFG_HAS_SWEEP: sweep_fitted = cfg_i.wdata[0];
          CFG_DUTY_0:    wave[0] = cfg_i.wdata;
          CFG_DUTY_1:    wave[1] = cfg_i.wdata;
          CFG_DUTY_2:    wave[2] = cfg_i.wdata;
          CFG_DUTY_3:    wave[3] = cfg_i.wdata;
          default: ;
        endcase
      end
      if (item_i.valid && item_i.ready) begin
        it.kind       = item_i.kind;
        it.reg_index  = item_i.reg_index;
        it.write_data = item_i.write_data;
        it.cycles     = item_i.cycles;
        pending_results.push_back(channel_step(it));
        outstanding_o++;
      end
    end
  end

endmodule

// File: verif/square_wave_sound_channel_tb.sv
// Top of the pulse channel testbench: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 100ps

module square_wave_sound_channel_tb;
  import sqw_pkg::*;

  localparam int HALF_PERIOD  = 4;
  localparam int RESET_CYCLES = 6;
  localparam int DRAIN_CYCLES = 8;
  localparam int LONG_HOLD    = 300;
  localparam int CYCLE_LIMIT  = 500000;

  localparam logic [2:0] KIND_BAD = 3'd6;
  localparam logic [2:0] REG_BAD  = 3'd5;

  logic clk = 1'b0;
  logic rst_n;
  int   fail_count;
  int   outstanding;
  int   cycle_cnt;
  bit   backpressure_req;
  bit   no_gaps;

  sqw_item_if   item_if ();
  sqw_result_if result_if ();
  sqw_cfg_if    cfg_if ();

  square_wave_sound_channel uut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .item_i   (item_if),
    .result_o (result_if),
    .cfg_i    (cfg_if)
  );

  sqw_channel_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .item_i        (item_if),
    .result_i      (result_if),
    .cfg_i         (cfg_if),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  always begin
    #(HALF_PERIOD) clk = 1'b1;
    #(HALF_PERIOD) clk = 1'b0;
  end

  // mostly short gaps, a few long ones
  function automatic int idle_gap();
    int roll;
    if (no_gaps) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic item_t item_of(logic [2:0] k, logic [2:0] r, logic [7:0] d, logic [7:0] c);
    item_t it;
    it.kind       = k;
    it.reg_index  = r;
    it.write_data = d;
    it.cycles     = c;
    return it;
  endfunction

  // Weighted toward triggers with the DAC on and short periods so the
  // duty position, envelope and sweep actually move.
  function automatic item_t rand_item();
    item_t it;
    int    pick;
    it.kind       = KIND_READ;
    it.reg_index  = 3'($urandom_range(0, 7));
    it.write_data = 8'($urandom);
    it.cycles     = 8'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 26) begin
      it.kind      = KIND_WRITE;
      it.reg_index = 3'($urandom_range(int'(REG_SWEEP), int'(REG_PER_HI)));
      case (it.reg_index)
        REG_VOL_ENV: if ($urandom_range(0, 9) == 0) it.write_data[7:3] = '0;
        REG_PER_HI: begin
          it.write_data[7] = ($urandom_range(0, 2) != 0);
          if ($urandom_range(0, 1) == 1) it.write_data[2:0] = 3'h7;
        end
        REG_PER_LO: if ($urandom_range(0, 1) == 1) it.write_data[7:6] = 2'b11;
        default: ;
      endcase
    end else if (pick < 36) begin
      it.kind = KIND_READ;
    end else if (pick < 66) begin
      it.kind = KIND_ADVANCE;
      if ($urandom_range(0, 4) == 0) it.cycles = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    end else if (pick < 76) begin
      it.kind = KIND_LENGTH;
    end else if (pick < 86) begin
      it.kind = KIND_ENVELOPE;
    end else if (pick < 96) begin
      it.kind = KIND_SWEEP;
    end else if ($urandom_range(0, 1) == 1) begin
      it.kind = KIND_BAD | 3'($urandom_range(0, 1));
    end else begin
      it.kind      = KIND_WRITE;
      it.reg_index = 3'($urandom_range(int'(REG_BAD), 7));
    end
    return it;
  endfunction

  // Offer one transaction, wait for acceptance, then maybe idle.
  task automatic send_item(input item_t it);
    int gap;
    item_if.valid      <= 1'b1;
    item_if.kind       <= it.kind;
    item_if.reg_index  <= it.reg_index;
    item_if.write_data <= it.write_data;
    item_if.cycles     <= it.cycles;
    @(posedge clk);
    while (!item_if.ready) @(posedge clk);
    gap = idle_gap();
    if (gap > 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic settle();
    item_if.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [7:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.addr  <= idx;
    cfg_if.wdata <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic sweep, input logic [7:0] w0, input logic [7:0] w1,
                            input logic [7:0] w2, input logic [7:0] w3);
    cfg_write(CFG_HAS_SWEEP, {7'd0, sweep});
    cfg_write(CFG_DUTY_0, w0);
    cfg_write(CFG_DUTY_1, w1);
    cfg_write(CFG_DUTY_2, w2);
    cfg_write(CFG_DUTY_3, w3);
  endtask

  task automatic run_random(input int count);
    for (int n = 0; n < count; n++) begin
      no_gaps = (n % 100) >= 70;
      send_item(rand_item());
    end
    no_gaps = 1'b0;
  endtask

  task automatic directed_defaults();
    send_item(item_of(KIND_READ, REG_LEN_DUTY, 8'h00, 8'h00));
    send_item(item_of(KIND_READ, REG_PER_HI, 8'h00, 8'h00));
    send_item(item_of(KIND_READ, REG_SWEEP, 8'h00, 8'h00));
    send_item(item_of(KIND_READ, 3'd7, 8'hFF, 8'hFF));
    // full volume, falling envelope, shortest length, max period with sweep up
    send_item(item_of(KIND_WRITE, REG_VOL_ENV, 8'hF1, 8'h00));
    send_item(item_of(KIND_WRITE, REG_LEN_DUTY, 8'hFF, 8'h00));
    send_item(item_of(KIND_WRITE, REG_PER_LO, 8'hFF, 8'h00));
    send_item(item_of(KIND_WRITE, REG_SWEEP, 8'h11, 8'h00));
    send_item(item_of(KIND_WRITE, REG_PER_HI, 8'hC7, 8'h00));
    send_item(item_of(KIND_ADVANCE, REG_SWEEP, 8'h00, 8'hFF));
    send_item(item_of(KIND_ADVANCE, REG_SWEEP, 8'h00, 8'h00));
    send_item(item_of(KIND_ADVANCE, REG_SWEEP, 8'h00, 8'h01));
    // length counter runs out
    send_item(item_of(KIND_LENGTH, REG_SWEEP, 8'h00, 8'h00));
    // volume clamps at 15
    send_item(item_of(KIND_WRITE, REG_VOL_ENV, 8'hF9, 8'h00));
    send_item(item_of(KIND_WRITE, REG_PER_HI, 8'h87, 8'h00));
    send_item(item_of(KIND_ENVELOPE, REG_SWEEP, 8'h00, 8'h00));
    send_item(item_of(KIND_ENVELOPE, REG_SWEEP, 8'h00, 8'h00));
    // volume clamps at 0
    send_item(item_of(KIND_WRITE, REG_VOL_ENV, 8'h11, 8'h00));
    send_item(item_of(KIND_WRITE, REG_PER_HI, 8'h87, 8'h00));
    send_item(item_of(KIND_ENVELOPE, REG_SWEEP, 8'h00, 8'h00));
    send_item(item_of(KIND_ENVELOPE, REG_SWEEP, 8'h00, 8'h00));
    // sweep overflow from the max period
    send_item(item_of(KIND_SWEEP, REG_SWEEP, 8'h00, 8'h00));
    // DAC off, then writes and kinds that are ignored
    send_item(item_of(KIND_WRITE, REG_VOL_ENV, 8'h00, 8'h00));
    send_item(item_of(KIND_WRITE, REG_BAD, 8'hFF, 8'h00));
    send_item(item_of(KIND_BAD, REG_PER_HI, 8'hFF, 8'hFF));
  endtask

  task automatic directed_no_sweep();
    send_item(item_of(KIND_WRITE, REG_VOL_ENV, 8'hF0, 8'h00));
    send_item(item_of(KIND_WRITE, REG_PER_HI, 8'h87, 8'h00));
    send_item(item_of(KIND_WRITE, REG_SWEEP, 8'h17, 8'h00));
    send_item(item_of(KIND_SWEEP, REG_SWEEP, 8'h00, 8'h00));
    send_item(item_of(KIND_READ, REG_LEN_DUTY, 8'h00, 8'h00));
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int gap;
    bit hold_done;
    hold_done = 1'b0;
    result_if.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (backpressure_req && !hold_done) begin
        result_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_done = 1'b1;
      end
      result_if.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      gap = idle_gap();
      if (gap > 0) begin
        result_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    no_gaps             = 1'b0;
    backpressure_req   <= 1'b0;
    item_if.valid      <= 1'b0;
    item_if.kind       <= KIND_WRITE;
    item_if.reg_index  <= REG_SWEEP;
    item_if.write_data <= 8'h00;
    item_if.cycles     <= 8'h00;
    cfg_if.valid       <= 1'b0;
    cfg_if.addr        <= CFG_HAS_SWEEP;
    cfg_if.wdata       <= 8'h00;
    rst_n              <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_defaults();
    run_random(300);
    settle();

    set_config(1'b0, 8'h00, 8'hFF, 8'hAA, 8'h55);
    directed_no_sweep();
    backpressure_req <= 1'b1;
    run_random(250);
    settle();

    set_config(1'b1, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    run_random(250);
    settle();

    set_config(1'b1, 8'hFF, 8'h00, 8'hFF, 8'h00);
    run_random(250);
    settle();

    set_config(1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    run_random(250);
    settle();

    set_config(HAS_SWEEP_RST, DUTY_0_RST, DUTY_1_RST, DUTY_2_RST, DUTY_3_RST);
    run_random(50);
    settle();

    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
